// ===== rtl/set_assoc_cache_model_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache model
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_MODEL_ASSERT_SVH
`define SET_ASSOC_CACHE_MODEL_ASSERT_SVH

// condition holds at every edge outside reset
`define SAC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("sac check failed");

// consequent holds in the cycle after the antecedent
`define SAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sac check failed");

`endif

// ===== rtl/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Types, register codes and helpers for the set-associative cache model.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int unsigned AddrInW = 48;
  localparam int unsigned CntW    = 32;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [2:0] REG_REPLACE_LRU = 3'd0;
  localparam logic [2:0] REG_PREFETCH_ON = 3'd1;
  localparam logic [2:0] REG_BLOCK_BITS  = 3'd2;
  localparam logic [2:0] REG_SET_BITS    = 3'd3;
  localparam logic [2:0] REG_WAYS_USED   = 3'd4;

  localparam logic [3:0] BlockBitsRst = 4'd6;
  localparam logic [3:0] SetBitsRst   = 4'd0;
  localparam logic [3:0] WaysUsedRst  = 4'd1;

  typedef struct packed {
    logic               func;
    logic [AddrInW-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic            hit;
    logic [1:0]      reads_added;
    logic            write_added;
    logic [CntW-1:0] hit_total;
    logic [CntW-1:0] miss_total;
    logic [CntW-1:0] read_total;
    logic [CntW-1:0] write_total;
  } out_item_t;

  typedef struct packed {
    logic       replace_lru;
    logic       prefetch_on;
    logic [3:0] block_bits;
    logic [3:0] set_bits;
    logic [3:0] ways_used;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/sac_front.sv =====
// ----------------------------------------------------------------------------
// sac_front
// Accepts accesses and splits them into set/tag for the demand block and
// the next block.
// ----------------------------------------------------------------------------
module sac_front #(
  parameter int unsigned ADDR_BITS      = 48,
  parameter int unsigned SET_INDEX_BITS = 8,
  localparam int unsigned SW = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1,
  localparam int unsigned EW = 1 + 2 * SW + 2 * ADDR_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sac_pkg::cfg_t       cfg_i,
  input  sac_pkg::back_stat_t stat_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sac_pkg::in_item_t   in_data_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output logic [EW-1:0]       q_data_o
);

  logic [ADDR_BITS-1:0] addr, naddr, msk, tag, ntag, set_full, nset_full;
  logic [3:0]           s;
  logic [4:0]           tshift;
  logic                 seen_q;

  // tracks that at least one access went through since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      seen_q <= 1'b1;
    end
  end

  always_comb begin
    addr   = ADDR_BITS'(in_data_i.address);
    s      = (cfg_i.set_bits > 4'(SET_INDEX_BITS)) ? 4'(SET_INDEX_BITS) : cfg_i.set_bits;
    msk    = ~({ADDR_BITS{1'b1}} << s);
    tshift = {1'b0, cfg_i.block_bits} + {1'b0, s};
    naddr  = addr + (ADDR_BITS'(1) << cfg_i.block_bits);
    set_full  = (addr >> cfg_i.block_bits) & msk;
    nset_full = (naddr >> cfg_i.block_bits) & msk;
    tag    = addr >> tshift;
    ntag   = naddr >> tshift;
  end

  assign in_ready_o = q_ready_i && !stat_i.clearing;
  assign q_valid_o  = in_valid_i && !stat_i.clearing && (seen_q || in_ready_o);
  assign q_data_o   = {in_data_i.func, SW'(set_full), tag, SW'(nset_full), ntag};

endmodule

// ===== rtl/sac_queue.sv =====
// ----------------------------------------------------------------------------
// sac_queue
// Two-entry queue between the classifier and the lookup engine.
// ----------------------------------------------------------------------------
module sac_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rp_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/sac_back.sv =====
// ----------------------------------------------------------------------------
// sac_back
// Post-reset set clear, set lookup, victim choice, line fill, stamps and running totals.
// ----------------------------------------------------------------------------
module sac_back #(
  parameter int unsigned ADDR_BITS      = 48,
  parameter int unsigned SET_INDEX_BITS = 8,
  parameter int unsigned MAX_WAYS       = 8,
  parameter int unsigned STAMP_BITS     = 48,
  localparam int unsigned SW    = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1,
  localparam int unsigned EW    = 1 + 2 * SW + 2 * ADDR_BITS,
  localparam int unsigned NSETS = 1 << SET_INDEX_BITS,
  localparam int unsigned WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int unsigned LVL   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0,
  localparam int unsigned P     = 1 << LVL
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sac_pkg::cfg_t       cfg_i,
  output sac_pkg::back_stat_t stat_o,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  logic [EW-1:0]       q_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sac_pkg::out_item_t  out_data_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UPD_D = 3'd2;
  localparam logic [2:0] ST_LOOK_P = 3'd3;
  localparam logic [2:0] ST_UPD_P = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  tag_mem [NSETS];
  logic [MAX_WAYS-1:0]                 vld_mem [NSETS];
  logic [MAX_WAYS-1:0][STAMP_BITS-1:0] stp_mem [NSETS];

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  rtag_q, wtag;
  logic [MAX_WAYS-1:0]                 rvld_q, wvld;
  logic [MAX_WAYS-1:0][STAMP_BITS-1:0] rstp_q, wstp;

  logic [2:0]            state_q, state_d;
  logic [SW-1:0]         clr_q, clr_d;
  logic [EW-1:0]         ent_q, ent_d;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d, stamp_nx;
  logic [31:0]           hits_q, hits_d, miss_q, miss_d, rds_q, rds_d, wrs_q, wrs_d;
  logic                  hit_q, hit_d;
  logic [1:0]            nrd_q, nrd_d;
  logic                  out_vld_q, out_vld_d;
  sac_pkg::out_item_t    out_q, out_d;

  logic                  mem_we;
  logic [SW-1:0]         ra, wa;
  logic [ADDR_BITS-1:0]  cmp_tag;
  logic [4:0]            eways;
  logic [MAX_WAYS-1:0]   wmask, hitv, invv;
  logic                  hit_any, inv_any;
  logic [WW-1:0]         hit_way, inv_way, vic_way;

  logic [STAMP_BITS-1:0] t_st [LVL+1][P];
  logic                  t_ok [LVL+1][P];
  logic [WW-1:0]         t_ix [LVL+1][P];

  wire                   ent_wr   = ent_q[EW-1];
  wire [SW-1:0]          ent_set  = ent_q[2*ADDR_BITS+SW +: SW];
  wire [ADDR_BITS-1:0]   ent_tag  = ent_q[ADDR_BITS+SW +: ADDR_BITS];
  wire [SW-1:0]          ent_nset = ent_q[ADDR_BITS +: SW];
  wire [ADDR_BITS-1:0]   ent_ntag = ent_q[ADDR_BITS-1:0];
  wire                   in_upd   = (state_q == ST_UPD_D) || (state_q == ST_UPD_P);

  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign q_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o     = out_vld_q;
  assign out_data_o      = out_q;

  assign ra = (state_q == ST_IDLE) ? q_data_i[2*ADDR_BITS+SW +: SW] : ent_nset;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[wa] <= wtag;
      vld_mem[wa] <= wvld;
      stp_mem[wa] <= wstp;
    end
    rtag_q <= tag_mem[ra];
    rvld_q <= vld_mem[ra];
    rstp_q <= stp_mem[ra];
  end

  // way match, first free way and oldest-stamp tree
  always_comb begin
    if (cfg_i.ways_used == 4'd0) begin
      eways = 5'd1;
    end else if ({1'b0, cfg_i.ways_used} > 5'(MAX_WAYS)) begin
      eways = 5'(MAX_WAYS);
    end else begin
      eways = {1'b0, cfg_i.ways_used};
    end
    cmp_tag = (state_q == ST_UPD_P) ? ent_ntag : ent_tag;
    for (int i = 0; i < MAX_WAYS; i++) begin
      wmask[i] = 5'(i) < eways;
      hitv[i]  = wmask[i] && rvld_q[i] && (rtag_q[i] == cmp_tag);
      invv[i]  = wmask[i] && !rvld_q[i];
    end
    hit_any = |hitv;
    inv_any = |invv;
    hit_way = '0;
    inv_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hitv[i]) hit_way = WW'(i);
      if (invv[i]) inv_way = WW'(i);
    end
    for (int i = 0; i < P; i++) begin
      t_st[0][i] = (i < MAX_WAYS) ? rstp_q[i % MAX_WAYS] : '0;
      t_ok[0][i] = (i < MAX_WAYS) ? wmask[i % MAX_WAYS] : 1'b0;
      t_ix[0][i] = WW'(i);
    end
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < P; i++) begin
        if (i < (P >> (l + 1))) begin
          if (t_ok[l][2*i+1] && (!t_ok[l][2*i] || t_st[l][2*i+1] <= t_st[l][2*i])) begin
            t_st[l+1][i] = t_st[l][2*i+1];
            t_ok[l+1][i] = 1'b1;
            t_ix[l+1][i] = t_ix[l][2*i+1];
          end else begin
            t_st[l+1][i] = t_st[l][2*i];
            t_ok[l+1][i] = t_ok[l][2*i];
            t_ix[l+1][i] = t_ix[l][2*i];
          end
        end else begin
          t_st[l+1][i] = '0;
          t_ok[l+1][i] = 1'b0;
          t_ix[l+1][i] = '0;
        end
      end
    end
    vic_way = inv_any ? inv_way : t_ix[LVL][0];
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ent_d     = ent_q;
    stamp_d   = stamp_q;
    stamp_nx  = stamp_q + 1'b1;
    hits_d    = hits_q;
    miss_d    = miss_q;
    rds_d     = rds_q;
    wrs_d     = wrs_q;
    hit_d     = hit_q;
    nrd_d     = nrd_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    wa        = (state_q == ST_UPD_P) ? ent_nset : ent_set;
    wtag      = rtag_q;
    wvld      = rvld_q;
    wstp      = rstp_q;

    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        wa     = clr_q;
        wvld   = '0;
        wstp   = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == SW'(NSETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          ent_d   = q_data_i;
          state_d = ST_UPD_D;
        end
      end
      ST_UPD_D: begin
        hit_d = hit_any;
        nrd_d = 2'd0;
        if (ent_wr) wrs_d = sac_pkg::sat_inc(wrs_q);
        if (hit_any) begin
          hits_d = sac_pkg::sat_inc(hits_q);
          if (cfg_i.replace_lru) begin
            mem_we          = 1'b1;
            wstp[hit_way]   = stamp_nx;
            stamp_d         = stamp_nx;
          end
          state_d = ST_DONE;
        end else begin
          miss_d        = sac_pkg::sat_inc(miss_q);
          rds_d         = sac_pkg::sat_inc(rds_q);
          nrd_d         = 2'd1;
          mem_we        = 1'b1;
          wvld[vic_way] = 1'b1;
          wtag[vic_way] = cmp_tag;
          wstp[vic_way] = stamp_nx;
          stamp_d       = stamp_nx;
          state_d       = cfg_i.prefetch_on ? ST_LOOK_P : ST_DONE;
        end
      end
      ST_LOOK_P: begin
        state_d = ST_UPD_P;
      end
      ST_UPD_P: begin
        if (!hit_any) begin
          rds_d         = sac_pkg::sat_inc(rds_q);
          nrd_d         = 2'd2;
          mem_we        = 1'b1;
          wvld[vic_way] = 1'b1;
          wtag[vic_way] = cmp_tag;
          wstp[vic_way] = stamp_nx;
          stamp_d       = stamp_nx;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d         = 1'b1;
          out_d.hit         = hit_q;
          out_d.reads_added = nrd_q;
          out_d.write_added = ent_wr;
          out_d.hit_total   = hits_q;
          out_d.miss_total  = miss_q;
          out_d.read_total  = rds_q;
          out_d.write_total = wrs_q;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (!in_upd) begin
      // stamp changes only on lookup updates
      stamp_d = (mem_we && state_q != ST_CLEAR) ? stamp_d : stamp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    hit_q <= hit_d;
    nrd_q <= nrd_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      stamp_q   <= '0;
      hits_q    <= '0;
      miss_q    <= '0;
      rds_q     <= '0;
      wrs_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      stamp_q   <= stamp_d;
      hits_q    <= hits_d;
      miss_q    <= miss_d;
      rds_q     <= rds_d;
      wrs_q     <= wrs_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== rtl/set_assoc_cache_model.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_model
// Write-through set-associative cache model with FIFO/LRU replacement and
// next-block prefetch.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one read or write
//   access per transaction; out channel (out_valid_o/out_ready_i/out_data_o)
//   returns one result per access, in order, with hit flag, reads and write
//   caused, and saturating running totals.
//   Accesses are classified in the front and wait in a two-entry queue for
//   the lookup engine. One set row is read per lookup, all ways compared at
//   once. In the engine an access passes through a set read, an update and
//   a result step; a prefetch set read and update come before the result
//   when a prefetch lookup follows a miss. The set memory read is registered.
//   After reset the engine clears valid bits and stamps one set per cycle,
//   all 2**SET_INDEX_BITS sets, with in_ready_o low; APB writes still work.
//   When the receiver stalls, the finished result holds in the output
//   register; the engine holds the next result and the queue keeps taking
//   accesses until full. The user writes configuration over APB only while
//   no access is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module set_assoc_cache_model #(
  parameter int unsigned ADDR_BITS      = 48,
  parameter int unsigned SET_INDEX_BITS = 8,
  parameter int unsigned MAX_WAYS       = 8,
  parameter int unsigned STAMP_BITS     = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sac_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sac_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned SW = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
  localparam int unsigned EW = 1 + 2 * SW + 2 * ADDR_BITS;

  sac_pkg::cfg_t       cfg_q, cfg_d;
  sac_pkg::back_stat_t stat;
  logic                fq_valid, fq_ready, bq_valid, bq_ready;
  logic [EW-1:0]       fq_data, bq_data;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[4:2])
        sac_pkg::REG_REPLACE_LRU: cfg_d.replace_lru = pwdata[0];
        sac_pkg::REG_PREFETCH_ON: cfg_d.prefetch_on = pwdata[0];
        sac_pkg::REG_BLOCK_BITS:  cfg_d.block_bits  = pwdata[3:0];
        sac_pkg::REG_SET_BITS:    cfg_d.set_bits    = pwdata[3:0];
        sac_pkg::REG_WAYS_USED:   cfg_d.ways_used   = pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      sac_pkg::REG_REPLACE_LRU: prdata = {31'd0, cfg_q.replace_lru};
      sac_pkg::REG_PREFETCH_ON: prdata = {31'd0, cfg_q.prefetch_on};
      sac_pkg::REG_BLOCK_BITS:  prdata = {28'd0, cfg_q.block_bits};
      sac_pkg::REG_SET_BITS:    prdata = {28'd0, cfg_q.set_bits};
      sac_pkg::REG_WAYS_USED:   prdata = {28'd0, cfg_q.ways_used};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.replace_lru <= 1'b0;
      cfg_q.prefetch_on <= 1'b0;
      cfg_q.block_bits  <= sac_pkg::BlockBitsRst;
      cfg_q.set_bits    <= sac_pkg::SetBitsRst;
      cfg_q.ways_used   <= sac_pkg::WaysUsedRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sac_front #(
    .ADDR_BITS      (ADDR_BITS),
    .SET_INDEX_BITS (SET_INDEX_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .stat_i     (stat),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_data_o   (fq_data)
  );

  sac_queue #(
    .DW (EW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (bq_data)
  );

  sac_back #(
    .ADDR_BITS      (ADDR_BITS),
    .SET_INDEX_BITS (SET_INDEX_BITS),
    .MAX_WAYS       (MAX_WAYS),
    .STAMP_BITS     (STAMP_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .stat_o      (stat),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_data_i    (bq_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/sac_checker.sv =====
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks for the set-associative cache model.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_model_assert.svh"

module sac_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sac_pkg::out_item_t out_data_o
);

  `SAC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `SAC_ASSERT_ALWAYS(a_hit_reads, !out_valid_o || (out_data_o.hit == (out_data_o.reads_added == 2'd0)))
  `SAC_ASSERT_ALWAYS(a_reads_max, !out_valid_o || (out_data_o.reads_added != 2'd3))
  `SAC_ASSERT_ALWAYS(a_clear_gate, !$rose(rst_ni) || !in_ready_o)

endmodule

bind set_assoc_cache_model sac_checker u_sac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== test/set_assoc_cache_model_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_model_test
// Drives read and write accesses through the cache model under several
// replacement, prefetch and geometry settings. A local model of the cache
// predicts each result, and every returned transaction is compared with it.
// ----------------------------------------------------------------------------
module set_assoc_cache_model_test;

  localparam int unsigned NumSets  = 256;
  localparam int unsigned WayCount = 8;

  typedef struct {
    int          phase;
    logic        func;
    logic [47:0] address;
    bit          known;
    logic        hit;
    logic [1:0]  reads;
  } dir_row_t;

  typedef struct {
    logic       lru;
    logic       pf;
    logic [3:0] bb;
    logic [3:0] sb;
    logic [3:0] wu;
    int         n_rand;
  } phase_cfg_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  sac_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  sac_pkg::out_item_t out_data_o;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic      pready;

  set_assoc_cache_model u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // cache image
  logic [47:0] tag_mem   [NumSets*WayCount];
  bit          valid_mem [NumSets*WayCount];
  logic [47:0] stamp_mem [NumSets*WayCount];
  logic [47:0] stamp_now;
  logic [31:0] hits_n, misses_n, reads_n, writes_n;
  sac_pkg::cfg_t cfg;

  sac_pkg::out_item_t pending_results[$];
  int        n_errors;
  bit        long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int ways_eff();
    if (cfg.ways_used == 4'd0) return 1;
    if (cfg.ways_used > WayCount) return WayCount;
    return cfg.ways_used;
  endfunction

  function automatic void locate(input logic [47:0] a, output int base,
                                 output logic [47:0] tag);
    int s;
    logic [47:0] set_idx;
    s = (cfg.set_bits > 4'd8) ? 8 : cfg.set_bits;
    set_idx = (a >> cfg.block_bits) & ((48'd1 << s) - 48'd1);
    tag = a >> (cfg.block_bits + s);
    base = int'(set_idx) * WayCount;
  endfunction

  function automatic int lookup(input int base, input logic [47:0] tag);
    for (int w = 0; w < ways_eff(); w++)
      if (valid_mem[base+w] && tag_mem[base+w] == tag) return w;
    return -1;
  endfunction

  function automatic void fill(input int base, input logic [47:0] tag);
    int pick;
    pick = -1;
    for (int w = 0; w < ways_eff(); w++)
      if (pick < 0 && !valid_mem[base+w]) pick = w;
    if (pick < 0) begin
      pick = 0;
      for (int w = 0; w < ways_eff(); w++)
        if (stamp_mem[base+w] <= stamp_mem[base+pick]) pick = w;
    end
    stamp_now = stamp_now + 48'd1;
    valid_mem[base+pick] = 1'b1;
    tag_mem[base+pick] = tag;
    stamp_mem[base+pick] = stamp_now;
  endfunction

  function automatic sac_pkg::out_item_t cache_access(input sac_pkg::in_item_t acc);
    sac_pkg::out_item_t r;
    int base, nbase, way;
    logic [47:0] tag, ntag;
    r = '0;
    locate(acc.address, base, tag);
    way = lookup(base, tag);
    if (way >= 0) begin
      r.hit = 1'b1;
      hits_n = bump(hits_n);
      if (cfg.replace_lru) begin
        stamp_now = stamp_now + 48'd1;
        stamp_mem[base+way] = stamp_now;
      end
    end else begin
      misses_n = bump(misses_n);
      reads_n = bump(reads_n);
      r.reads_added = 2'd1;
      fill(base, tag);
      if (cfg.prefetch_on) begin
        locate(acc.address + (48'd1 << cfg.block_bits), nbase, ntag);
        if (lookup(nbase, ntag) < 0) begin
          reads_n = bump(reads_n);
          r.reads_added = 2'd2;
          fill(nbase, ntag);
        end
      end
    end
    if (acc.func) writes_n = bump(writes_n);
    r.write_added = acc.func;
    r.hit_total = hits_n;
    r.miss_total = misses_n;
    r.read_total = reads_n;
    r.write_total = writes_n;
    return r;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sac_pkg::REG_REPLACE_LRU: cfg.replace_lru = val[0];
      sac_pkg::REG_PREFETCH_ON: cfg.prefetch_on = val[0];
      sac_pkg::REG_BLOCK_BITS:  cfg.block_bits = val[3:0];
      sac_pkg::REG_SET_BITS:    cfg.set_bits = val[3:0];
      sac_pkg::REG_WAYS_USED:   cfg.ways_used = val[3:0];
      default: ;
    endcase
  endtask

  // one transaction; valid stays high for the caller to lower
  task automatic push_access(input sac_pkg::in_item_t acc, input bit known,
                             input logic hit, input logic [1:0] reads);
    sac_pkg::out_item_t r;
    in_valid_i <= 1'b1;
    in_data_i <= acc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = cache_access(acc);
    if (known) begin
      r.hit = hit;
      r.reads_added = reads;
    end
    pending_results.push_back(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // receiver
  initial begin
    int mode;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      for (int c = 0; c < 40; c++) begin
        @(posedge clk_i);
        if (long_hold_req) begin
          out_ready_i <= 1'b0;
          repeat (150) @(posedge clk_i);
          long_hold_req = 1'b0;
        end
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sac_pkg::out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending access");
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data_o.hit !== e.hit) begin
          $error("hit exp %0h got %0h", e.hit, out_data_o.hit); n_errors++;
        end
        if (out_data_o.reads_added !== e.reads_added) begin
          $error("reads_added exp %0h got %0h", e.reads_added, out_data_o.reads_added);
          n_errors++;
        end
        if (out_data_o.write_added !== e.write_added) begin
          $error("write_added exp %0h got %0h", e.write_added, out_data_o.write_added);
          n_errors++;
        end
        if (out_data_o.hit_total !== e.hit_total) begin
          $error("hit_total exp %0d got %0d", e.hit_total, out_data_o.hit_total);
          n_errors++;
        end
        if (out_data_o.miss_total !== e.miss_total) begin
          $error("miss_total exp %0d got %0d", e.miss_total, out_data_o.miss_total);
          n_errors++;
        end
        if (out_data_o.read_total !== e.read_total) begin
          $error("read_total exp %0d got %0d", e.read_total, out_data_o.read_total);
          n_errors++;
        end
        if (out_data_o.write_total !== e.write_total) begin
          $error("write_total exp %0d got %0d", e.write_total, out_data_o.write_total);
          n_errors++;
        end
      end
    end
  end

  dir_row_t   dir_rows[$];
  phase_cfg_t phases[$];

  initial begin
    logic [47:0] pool[16];
    sac_pkg::in_item_t acc;
    int burst;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    n_errors = 0;
    long_hold_req = 1'b0;
    foreach (valid_mem[i]) begin
      valid_mem[i] = 1'b0;
      stamp_mem[i] = '0;
      tag_mem[i] = '0;
    end
    stamp_now = '0;
    {hits_n, misses_n, reads_n, writes_n} = '0;
    cfg = '{replace_lru: 1'b0, prefetch_on: 1'b0, block_bits: sac_pkg::BlockBitsRst,
            set_bits: sac_pkg::SetBitsRst, ways_used: sac_pkg::WaysUsedRst};

    // reset geometry: direct mapped, one set, 64-byte blocks
    dir_rows = '{
      '{0, 1'b0, 48'h0,            1, 1'b0, 2'd1},
      '{0, 1'b0, 48'h3F,           1, 1'b1, 2'd0},
      '{0, 1'b1, 48'hFFFF_FFFF_FFFF, 1, 1'b0, 2'd1},
      '{0, 1'b0, 48'h0,            1, 1'b0, 2'd1},
      '{0, 1'b1, 48'h0,            1, 1'b1, 2'd0},
      '{1, 1'b0, 48'hFFFF_FFFF_FFFF, 0, 1'b0, 2'd0},
      '{1, 1'b0, 48'h0,            0, 1'b0, 2'd0},
      '{1, 1'b1, 48'h100,          0, 1'b0, 2'd0},
      '{1, 1'b0, 48'h200,          0, 1'b0, 2'd0},
      '{1, 1'b0, 48'h100,          0, 1'b0, 2'd0},
      '{1, 1'b1, 48'h300,          0, 1'b0, 2'd0},
      '{1, 1'b0, 48'h1,            0, 1'b0, 2'd0},
      '{2, 1'b0, 48'h0,            0, 1'b0, 2'd0},
      '{2, 1'b1, 48'h8000,         0, 1'b0, 2'd0},
      '{2, 1'b0, 48'hFFFF_FFFF_8000, 0, 1'b0, 2'd0},
      '{2, 1'b0, 48'h7FFF,         0, 1'b0, 2'd0},
      '{2, 1'b1, 48'hAAAA_AAAA_AAAA, 0, 1'b0, 2'd0},
      '{2, 1'b0, 48'h5555_5555_5555, 0, 1'b0, 2'd0}
    };
    phases = '{
      '{1'b0, 1'b0, 4'd6,  4'd0,  4'd1,  150},
      '{1'b1, 1'b1, 4'd0,  4'd8,  4'd8,  160},
      '{1'b0, 1'b1, 4'd15, 4'd15, 4'd0,  150},
      '{1'b1, 1'b0, 4'd3,  4'd2,  4'd4,  160},
      '{1'b0, 1'b0, 4'd12, 4'd1,  4'd15, 160},
      '{1'b1, 1'b1, 4'd4,  4'd3,  4'd2,  170},
      '{1'b0, 1'b1, 4'd13, 4'd9,  4'd3,  160},
      '{1'b1, 1'b0, 4'd0,  4'd0,  4'd8,  160},
      '{1'b0, 1'b0, 4'd2,  4'd4,  4'd1,  160},
      '{1'b1, 1'b1, 4'd6,  4'd1,  4'd5,  160}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (phases[p]) begin
      if (p != 0) begin
        apb_write(sac_pkg::REG_REPLACE_LRU, {31'($urandom), phases[p].lru});
        apb_write(sac_pkg::REG_PREFETCH_ON, {31'($urandom), phases[p].pf});
        apb_write(sac_pkg::REG_BLOCK_BITS, {28'($urandom), phases[p].bb});
        apb_write(sac_pkg::REG_SET_BITS, {28'($urandom), phases[p].sb});
        apb_write(sac_pkg::REG_WAYS_USED, {28'($urandom), phases[p].wu});
        apb_write(3'd5 + 3'($urandom_range(0, 2)), $urandom);
      end
      foreach (dir_rows[r])
        if (dir_rows[r].phase == p) begin
          acc.func = dir_rows[r].func;
          acc.address = dir_rows[r].address;
          push_access(acc, dir_rows[r].known, dir_rows[r].hit, dir_rows[r].reads);
        end
      foreach (pool[i]) pool[i] = {16'($urandom), 32'($urandom)};
      if (p == 4) long_hold_req = 1'b1;
      burst = 0;
      for (int n = 0; n < phases[p].n_rand; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          if ($urandom_range(0, 2) != 0) begin
            in_valid_i <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk_i);
          end
        end
        burst--;
        acc.func = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
          acc.address = {16'($urandom), 32'($urandom)};
        else
          acc.address = pool[$urandom_range(0, 15)] +
                        (48'($urandom_range(0, 5)) << phases[p].bb) +
                        48'($urandom_range(0, 3));
        push_access(acc, 0, 1'b0, 2'd0);
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
